[rtl/int64_to_float_convert_defines.svh]
// Assertion macros for the int64 to float converter.
// Used by rtl/int64_to_float_convert.sv.
`ifndef INT64_TO_FLOAT_CONVERT_DEFINES_SVH
`define INT64_TO_FLOAT_CONVERT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ITF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ITF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/itf_pkg.sv]
// Types and constants for the int64 to float converter.
// No dependencies.
package itf_pkg;

  typedef enum logic [1:0] {
    OP_S2D = 2'd0,
    OP_U2D = 2'd1,
    OP_S2F = 2'd2,
    OP_U2F = 2'd3
  } op_t;

  localparam int unsigned DBL_FRAC = 52;
  localparam int unsigned SGL_FRAC = 23;
  localparam logic [10:0] DBL_BIAS = 11'd1023;
  localparam logic [7:0]  SGL_BIAS = 8'd127;

  // Per-item control carried down the pipe.
  typedef struct packed {
    logic neg;
    logic single;
    logic zero;
  } itf_ctl_t;

endpackage

[rtl/itf_lzc.sv]
// Leading-zero count of a 64-bit word, as a 2-level tree over 8-bit groups.
// Uses nothing from the package.
module itf_lzc (
  input  logic [63:0] word,
  output logic [5:0]  count
);

  logic [7:0] grp_nz;
  logic [2:0] grp_lz [8];
  logic [2:0] top;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |word[g*8 +: 8];
      grp_lz[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (word[g*8 + b]) grp_lz[g] = 3'(7 - b);
      end
    end
    top = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz[g]) top = 3'(7 - g);
    end
    count = {top, grp_lz[3'(7) - top]};
  end

endmodule

[rtl/int64_to_float_convert.sv]
// Top level: 64-bit integer to binary64/binary32 converter, round to nearest even.
// Depends on itf_pkg, itf_lzc and int64_to_float_convert_defines.svh.
//
//  channel | signals               | direction
//  in      | in_valid, in_ready, op, int_bits | into block
//  out     | out_valid, out_ready, float_bits | out of block
//
// Four register stages: negate, leading-zero count, normalize shift, round/pack.
// One item per cycle when the output is not stalled.
// Reset clears the stage valid bits only; no other state.
// A stall on out_ready freezes the whole pipe; in_ready drops only when the
// last stage holds an item that is not taken.
`include "int64_to_float_convert_defines.svh"
module int64_to_float_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] int_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] float_bits
);
  import itf_pkg::*;

  logic adv;
  assign adv = ~out_valid | out_ready;
  assign in_ready = adv;

  // stage 1: magnitude
  logic        v1;
  itf_ctl_t    c1;
  logic [63:0] mag1;
  // stage 2: leading zeros
  logic        v2;
  itf_ctl_t    c2;
  logic [63:0] mag2;
  logic [5:0]  lz2;
  // stage 3: normalized word, msb at bit 63
  logic        v3;
  itf_ctl_t    c3;
  logic [63:0] norm3;
  logic [5:0]  lz3;
  // stage 4: packed result
  logic        v4;
  logic [63:0] res4;

  // round and pack from the normalized word
  logic [63:0] res_c;
  logic [52:0] dsig;
  logic [53:0] dsum;
  logic        dinc;
  logic [10:0] dexp;
  logic [23:0] ssig;
  logic [24:0] ssum;
  logic        sinc;
  logic [7:0]  sexp;
  logic [6:0]  msb;

  logic c4_single_seen;

  op_t in_op;
  logic in_neg;
  assign in_op  = op_t'(op);
  assign in_neg = (in_op == OP_S2D || in_op == OP_S2F) && int_bits[63];

  logic [5:0] lz_c;
  itf_lzc u_lzc (.word(mag1), .count(lz_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1.neg    <= in_neg;
      c1.single <= (in_op == OP_S2F || in_op == OP_U2F);
      c1.zero   <= (int_bits == 64'd0);
      mag1      <= in_neg ? (64'd0 - int_bits) : int_bits;
      c2   <= c1;
      mag2 <= mag1;
      lz2  <= lz_c;
      c3    <= c2;
      norm3 <= mag2 << lz2;
      lz3   <= lz2;
      res4  <= res_c;
    end
  end

  always_comb begin
    msb  = 7'd63 - {1'b0, lz3};
    dsig = norm3[63:11];
    dinc = norm3[10] & ((|norm3[9:0]) | norm3[11]);
    dsum = {1'b0, dsig} + {53'd0, dinc};
    dexp = DBL_BIAS + {4'd0, msb} + {10'd0, dsum[53]};
    ssig = norm3[63:40];
    sinc = norm3[39] & ((|norm3[38:0]) | norm3[40]);
    ssum = {1'b0, ssig} + {24'd0, sinc};
    sexp = SGL_BIAS + {1'b0, msb} + {7'd0, ssum[24]};
    if (c3.zero) begin
      res_c = 64'd0;
    end else if (c3.single) begin
      // on carry the fraction is all zero either way
      res_c = {32'd0, c3.neg, sexp, ssum[22:0]};
    end else begin
      res_c = {c3.neg, dexp, dsum[51:0]};
    end
  end

  assign out_valid  = v4;
  assign float_bits = res4;

  always_ff @(posedge clk) begin
    if (adv) c4_single_seen <= c3.single & ~c3.zero;
  end

  `ITF_ASSERT_IMPL(a_single_upper_zero, clk, rst, out_valid && c4_single_seen, float_bits[63:32] == 32'd0, "single result has nonzero upper bits")
  `ITF_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(float_bits), "stalled result changed")
  `ITF_ASSERT_IMPL(a_norm_msb, clk, rst, v3 && !c3.zero, norm3[63], "normalized word lacks leading one")

endmodule

[tb/itf_checker.sv]
// Scoreboard for int64_to_float_convert: watches both channels, predicts each
// conversion with round-to-nearest-even, compares in order. Depends on itf_pkg.
module itf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] int_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] float_bits,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import itf_pkg::*;

  logic [63:0] expected_floats[$];

  // Round a nonzero magnitude to nfrac fraction bits, ties to even, and pack.
  function automatic logic [63:0] round_pack(logic neg, logic [63:0] mag, int nfrac,
                                             int bias, int width);
    int msb;
    int sh;
    logic [63:0] sig;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] fmask;
    logic [63:0] res;
    msb = 63;
    while (msb > 0 && !mag[msb]) msb--;
    fmask = (64'd1 << nfrac) - 1;
    if (msb <= nfrac) begin
      sig = mag << (nfrac - msb);
    end else begin
      sh = msb - nfrac;
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      sig = mag >> sh;
      if (rem > half || (rem == half && sig[0])) begin
        sig++;
        if ((sig >> (nfrac + 1)) != 0) begin
          sig = sig >> 1;
          msb++;
        end
      end
    end
    res = (64'(neg) << (width - 1)) | (64'(msb + bias) << nfrac) | (sig & fmask);
    return res;
  endfunction

  function automatic logic [63:0] convert_int(op_t code, logic [63:0] x);
    logic sgn;
    logic neg;
    logic [63:0] mag;
    sgn = (code == OP_S2D || code == OP_S2F);
    neg = sgn && x[63];
    mag = neg ? -x : x;
    if (mag == 0) return 64'd0;
    if (code == OP_S2F || code == OP_U2F)
      return round_pack(neg, mag, SGL_FRAC, SGL_BIAS, 32) & 64'hFFFF_FFFF;
    return round_pack(neg, mag, DBL_FRAC, DBL_BIAS, 64);
  endfunction

  logic [63:0] want;

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) expected_floats.push_back(convert_int(op_t'(op), int_bits));
      if (out_valid && out_ready) begin
        if (expected_floats.size() == 0) begin
          $error("float_bits: unexpected item, actual %h", float_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_floats.pop_front();
          if (want !== float_bits) begin
            $error("float_bits: expected %h actual %h", want, float_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = expected_floats.size();
endmodule

[tb/tb.sv]
// Top of the int64_to_float_convert testbench: clock, reset, stimulus, verdict.
// Depends on itf_pkg, itf_checker and the converter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itf_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [63:0] int_bits;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] float_bits;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          stim_done;

  int64_to_float_convert dut (.*);
  itf_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("int64_to_float_convert regression: fail");
      $finish;
    end
  end

  // Random receiver stalls, sometimes none at all.
  initial begin
    int gap;
    out_ready = 0;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      out_ready <= 0;
      repeat (gap) @(negedge clk);
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(logic [1:0] code, logic [63:0] val, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    op <= code;
    int_bits <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random words, some near rounding: runs of ones or tie patterns at a random spot.
  function automatic logic [63:0] rand_value();
    int kind;
    int p;
    logic [63:0] v;
    kind = $urandom_range(0, 5);
    v = {$urandom(), $urandom()};
    p = $urandom_range(0, 63);
    case (kind)
      0: v = v >> $urandom_range(0, 63);
      1: v = (64'd1 << p) | ((64'd1 << $urandom_range(0, p)) >> 1);
      2: v = (64'd1 << p) - 1;
      3: v = -(v >> $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  logic [63:0] directed_vals[12] = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0020_0000_0000_0001,
    64'h0020_0000_0000_0003, 64'h0000_0000_0100_0001, 64'h0000_0000_0300_0001,
    64'h0000_0000_00FF_FFFF, 64'hFFFF_FFFF_FF00_0001, 64'h001F_FFFF_FFFF_FFFF};

  initial begin
    int gap;
    rst = 1;
    in_valid = 0;
    op = OP_S2D;
    int_bits = 0;
    stim_done = 0;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (directed_vals[i])
      for (int c = 0; c < 4; c++) send_item(c[1:0], directed_vals[i], 0);
    for (int n = 0; n < 1400; n++) begin
      gap = (n % 300 < 60) ? 0 : $urandom_range(0, 4);
      send_item(2'($urandom_range(0, 3)), rand_value(), gap);
    end
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("int64_to_float_convert regression: pass");
    end else begin
      $display("int64_to_float_convert regression: fail");
    end
    $finish;
  end
endmodule
